// ===== rtl/lkc_pkg.sv =====
// constants and sequencer state type for the keyed lzss compressor
// no dependencies
package lkc_pkg;

    localparam int WindowBits = 12;
    localparam int MaxMatch = 17;
    localparam int LaDepth = MaxMatch + 1;
    localparam int TabBits = 16;
    localparam int NumKeys = 8;
    localparam logic [7:0] FlagMask = 8'hC8;
    localparam logic [11:0] MaxDist = 12'hFFF;

    localparam logic [15:0] KeyReset [NumKeys] = '{
        16'hFF21, 16'h834F, 16'h675F, 16'h0034,
        16'hF237, 16'h815F, 16'h4765, 16'h0233
    };

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_CLEAR = 13'b0000000000010,
        ST_LOOK  = 13'b0000000000100,
        ST_TAB   = 13'b0000000001000,
        ST_MRD   = 13'b0000000010000,
        ST_MCMP  = 13'b0000000100000,
        ST_CODE  = 13'b0000001000000,
        ST_CONS  = 13'b0000010000000,
        ST_POST  = 13'b0000100000000,
        ST_SFLAG = 13'b0001000000000,
        ST_SSYM  = 13'b0010000000000,
        ST_SHI   = 13'b0100000000000,
        ST_FIN   = 13'b1000000000000
    } lkc_state_t;

endpackage

// ===== rtl/lzss_keyed_compressor.sv =====
// keyed lzss stream compressor, one byte per request in, one byte per request out
// uses lkc_pkg for constants and the sequencer state type
// a byte that codes a symbol holds s_tready low through the table lookup, the match compares,
//   the history update and, when its group fills, the sending and closing of the group
// other bytes are taken in ST_IDLE; compares use the single history read port, each in ST_MRD then ST_MCMP
// reset and every stream end clear the position table entry by entry; keys reset on reset only
module lzss_keyed_compressor #(
    parameter int POS_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser,   // [0] too_long
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);
    import lkc_pkg::*;

    localparam int TabEntries = 1 << TabBits;
    localparam int WinEntries = 1 << WindowBits;

    lkc_state_t state_reg;

    logic [POS_BITS:0]     tab_mem [TabEntries];
    logic [7:0]            hist_mem [WinEntries];
    logic [POS_BITS:0]     tab_q;
    logic [7:0]            hist_q;

    logic [15:0]           key_reg [NumKeys];
    logic [7:0]            la_reg [LaDepth];
    logic [4:0]            cnt_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic                  ovf_reg;
    logic                  ovf_pred_reg;
    logic                  step_last_reg;
    logic                  send_final_reg;
    logic [7:0]            flag_reg;
    logic [7:0]            gb_reg [16];
    logic [3:0]            syms_reg;
    logic [4:0]            glen_reg;
    logic [4:0]            m_reg;
    logic [4:0]            lim_reg;
    logic [4:0]            cons_reg;
    logic [11:0]           dist_reg;
    logic [3:0]            sidx_reg;
    logic [4:0]            r_reg;
    logic [15:0]           key_sel_reg;
    logic [TabBits-1:0]    clr_reg;

    logic                  m_tvalid_reg;
    logic [7:0]            m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic [TabBits-1:0]    tab_addr;
    logic [WindowBits-1:0] hist_raddr;
    logic [POS_BITS-1:0]   back_dist;
    logic                  reject;
    logic [4:0]            lim_a;
    logic [4:0]            cnt_new;
    logic [POS_BITS:0]     psum;
    logic                  out_free;
    logic                  emit;
    logic                  tab_we;
    logic [TabBits-1:0]    tab_waddr;
    logic [POS_BITS:0]     tab_wdata;
    logic                  hist_we;
    logic                  too_long_now;
    logic [7:0]            masked;
    logic [3:0]            sidx_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit = out_free && ((state_reg == ST_SFLAG) || (state_reg == ST_SHI) ||
                  ((state_reg == ST_SSYM) && (sidx_reg < syms_reg) && (r_reg < 5'd16)));
    assign tab_addr = {la_reg[1], la_reg[0]};
    assign hist_raddr = pos_reg[WindowBits-1:0] - dist_reg + WindowBits'(m_reg);
    assign back_dist = pos_reg - tab_q[POS_BITS-1:0];
    assign reject = !tab_q[POS_BITS] || (back_dist < POS_BITS'(2)) ||
                    (back_dist > POS_BITS'(MaxDist));
    assign lim_a = (cnt_reg > 5'(MaxMatch)) ? 5'(MaxMatch) : cnt_reg;
    assign cnt_new = (cnt_reg < 5'(LaDepth)) ? cnt_reg + 5'd1 : cnt_reg;
    assign psum = {1'b0, pos_reg} + (POS_BITS+1)'(cnt_new);
    assign too_long_now = step_last_reg ? ovf_pred_reg : ovf_reg;
    assign masked = flag_reg ^ FlagMask;
    assign sidx_inc = sidx_reg + 4'd1;

    // single write port on the position table: clearing pass or update on a rejected lookup
    always_comb begin
        tab_we = 1'b0;
        tab_waddr = tab_addr;
        tab_wdata = {1'b1, pos_reg};
        if (state_reg == ST_CLEAR) begin
            tab_we = 1'b1;
            tab_waddr = clr_reg;
            tab_wdata = '0;
        end else if (state_reg == ST_TAB && reject) begin
            tab_we = 1'b1;
        end
    end

    assign hist_we = (state_reg == ST_CONS) && (cons_reg != 5'd0) && (cnt_reg != 5'd0);

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_q <= tab_mem[tab_addr];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[pos_reg[WindowBits-1:0]] <= la_reg[0];
        end
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
            ovf_reg <= 1'b0;
            ovf_pred_reg <= 1'b0;
            step_last_reg <= 1'b0;
            send_final_reg <= 1'b0;
            flag_reg <= '0;
            syms_reg <= '0;
            glen_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < NumKeys; k++) begin
                key_reg[k] <= KeyReset[k];
            end
        end else begin
            if (cfg_wr_en) begin
                key_reg[cfg_index] <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && !emit) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (cnt_reg < 5'(LaDepth)) begin
                            la_reg[cnt_reg] <= s_tdata;
                        end
                        cnt_reg <= cnt_new;
                        step_last_reg <= s_tlast;
                        ovf_pred_reg <= ovf_reg | psum[POS_BITS];
                        if (s_tlast || cnt_new >= 5'(MaxMatch)) begin
                            state_reg <= ST_LOOK;
                        end
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + TabBits'(1);
                    if (clr_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LOOK: begin
                    m_reg <= '0;
                    if (cnt_reg == 5'd0) begin
                        if (syms_reg != 4'd0) begin
                            send_final_reg <= 1'b1;
                            state_reg <= ST_SFLAG;
                        end else begin
                            state_reg <= ST_FIN;
                        end
                    end else if (cnt_reg >= 5'd2) begin
                        state_reg <= ST_TAB;
                    end else begin
                        state_reg <= ST_CODE;
                    end
                end
                ST_TAB: begin
                    if (reject) begin
                        state_reg <= ST_CODE;
                    end else begin
                        dist_reg <= back_dist[11:0];
                        lim_reg <= (back_dist[11:0] < 12'(lim_a)) ? back_dist[4:0] : lim_a;
                        state_reg <= ST_MRD;
                    end
                end
                ST_MRD: begin
                    state_reg <= (m_reg < lim_reg) ? ST_MCMP : ST_CODE;
                end
                ST_MCMP: begin
                    if (hist_q == la_reg[m_reg]) begin
                        m_reg <= m_reg + 5'd1;
                        state_reg <= ST_MRD;
                    end else begin
                        state_reg <= ST_CODE;
                    end
                end
                ST_CODE: begin
                    if (m_reg >= 5'd2) begin
                        gb_reg[glen_reg[3:0]] <= dist_reg[7:0];
                        gb_reg[glen_reg[3:0] + 4'd1] <= {4'(m_reg - 5'd2), dist_reg[11:8]};
                        glen_reg <= glen_reg + 5'd2;
                        flag_reg <= flag_reg | (8'd1 << syms_reg[2:0]);
                        cons_reg <= m_reg;
                    end else begin
                        gb_reg[glen_reg[3:0]] <= la_reg[0];
                        glen_reg <= glen_reg + 5'd1;
                        cons_reg <= 5'd1;
                    end
                    syms_reg <= syms_reg + 4'd1;
                    state_reg <= ST_CONS;
                end
                ST_CONS: begin
                    if (hist_we) begin
                        for (int k = 0; k < LaDepth - 1; k++) begin
                            la_reg[k] <= la_reg[k+1];
                        end
                        cnt_reg <= cnt_reg - 5'd1;
                        pos_reg <= pos_reg + POS_BITS'(1);
                        if (pos_reg == '1) begin
                            ovf_reg <= 1'b1;
                        end
                        cons_reg <= cons_reg - 5'd1;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (syms_reg >= 4'd8) begin
                        send_final_reg <= step_last_reg && (cnt_reg == 5'd0);
                        state_reg <= ST_SFLAG;
                    end else begin
                        state_reg <= step_last_reg ? ST_LOOK : ST_IDLE;
                    end
                end
                ST_SFLAG: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= masked;
                        m_tlast_reg <= 1'b0;
                        m_tuser_reg <= too_long_now;
                        key_sel_reg <= key_reg[masked[5:3]];
                        sidx_reg <= '0;
                        r_reg <= '0;
                        state_reg <= ST_SSYM;
                    end
                end
                ST_SSYM: begin
                    if (sidx_reg < syms_reg && r_reg < 5'd16) begin
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tuser_reg <= too_long_now;
                            if (flag_reg[sidx_reg[2:0]]) begin
                                m_tdata_reg <= gb_reg[r_reg[3:0]] ^ key_sel_reg[7:0];
                                m_tlast_reg <= 1'b0;
                                state_reg <= ST_SHI;
                            end else begin
                                m_tdata_reg <= gb_reg[r_reg[3:0]];
                                m_tlast_reg <= send_final_reg &&
                                    (sidx_inc == syms_reg || r_reg + 5'd1 >= 5'd16);
                                r_reg <= r_reg + 5'd1;
                                sidx_reg <= sidx_inc;
                            end
                        end
                    end else begin
                        // group done
                        flag_reg <= '0;
                        syms_reg <= '0;
                        glen_reg <= '0;
                        if (send_final_reg) begin
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= step_last_reg ? ST_LOOK : ST_IDLE;
                        end
                    end
                end
                ST_SHI: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg <= too_long_now;
                        m_tdata_reg <= gb_reg[r_reg[3:0] + 4'd1] ^ key_sel_reg[15:8];
                        m_tlast_reg <= send_final_reg &&
                            (sidx_inc == syms_reg || r_reg + 5'd2 >= 5'd16);
                        r_reg <= r_reg + 5'd2;
                        sidx_reg <= sidx_inc;
                        state_reg <= ST_SSYM;
                    end
                end
                ST_FIN: begin
                    cnt_reg <= '0;
                    pos_reg <= '0;
                    ovf_reg <= 1'b0;
                    flag_reg <= '0;
                    syms_reg <= '0;
                    glen_reg <= '0;
                    send_final_reg <= 1'b0;
                    step_last_reg <= 1'b0;
                    clr_reg <= '0;
                    state_reg <= ST_CLEAR;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/lzss_keyed_compressor_tb.sv =====
// self-checking testbench for lzss_keyed_compressor: random and directed byte streams in,
// compressed bytes checked against an in-bench model of the keyed lzss coder
// depends on lkc_pkg and the compressor rtl
module lzss_keyed_compressor_tb;
    import lkc_pkg::*;

    localparam int IdleLimit = 300000;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } raw_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       too_long;
    } coded_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wr_data = '0;

    lzss_keyed_compressor u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    raw_byte_t   raw_q[$];
    coded_byte_t coded_q[$];
    logic [7:0]  step_q[$];
    int          fails = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    bit          s_took = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    // model state
    logic [15:0] keys [NumKeys];
    logic [7:0]  hist [4096];
    logic [7:0]  la [LaDepth];
    int          la_n;
    logic [31:0] pos_tab [65536];
    bit          pos_ok [65536];
    logic [31:0] pos;
    bit          ovf;
    logic [7:0]  gflag;
    logic [7:0]  gbytes [16];
    int          gsym;
    int          glen;

    function automatic void clear_stream();
        foreach (pos_ok[i]) pos_ok[i] = 1'b0;
        pos = '0;
        ovf = 1'b0;
        la_n = 0;
        gflag = '0;
        gsym = 0;
        glen = 0;
    endfunction

    function automatic void send_group();
        logic [7:0]  masked;
        logic [15:0] key;
        logic [15:0] w;
        int          r;
        if (gsym == 0) return;
        masked = gflag ^ FlagMask;
        step_q.push_back(masked);
        key = keys[masked[5:3]];
        r = 0;
        for (int i = 0; i < gsym && r < 16; i++) begin
            if (gflag[3'(i)]) begin
                w = {gbytes[4'(r + 1)], gbytes[4'(r)]} ^ key;
                step_q.push_back(w[7:0]);
                step_q.push_back(w[15:8]);
                r += 2;
            end else begin
                step_q.push_back(gbytes[4'(r)]);
                r += 1;
            end
        end
        gflag = '0;
        gsym = 0;
        glen = 0;
    endfunction

    function automatic void consume(int cnt);
        if (cnt > la_n) cnt = la_n;
        for (int i = 0; i < cnt; i++) begin
            hist[pos[11:0]] = la[5'(i)];
            pos = pos + 1;
            if (pos == 0) ovf = 1'b1;
        end
        for (int i = 0; i + cnt < la_n; i++) la[5'(i)] = la[5'(i + cnt)];
        la_n -= cnt;
    endfunction

    function automatic void code_symbol();
        int          mlen;
        int          lim;
        logic [31:0] gap;
        logic [15:0] pair;
        logic [15:0] w;
        mlen = 0;
        gap = '0;
        if (la_n == 0) return;
        if (la_n >= 2) begin
            pair = {la[1], la[0]};
            gap = pos - pos_tab[pair];
            if (!pos_ok[pair] || gap < 2 || gap > 32'(MaxDist)) begin
                pos_tab[pair] = pos;
                pos_ok[pair] = 1'b1;
            end else begin
                lim = la_n;
                if (lim > gap) lim = int'(gap);
                if (lim > MaxMatch) lim = MaxMatch;
                while (mlen < lim && hist[12'(pos - gap + 32'(mlen))] == la[5'(mlen)])
                    mlen++;
            end
        end
        if (mlen >= 2) begin
            w = {4'(mlen - 2), gap[11:0]};
            gflag[3'(gsym)] = 1'b1;
            gbytes[4'(glen)] = w[7:0];
            gbytes[4'(glen + 1)] = w[15:8];
            glen += 2;
            consume(mlen);
        end else begin
            gbytes[4'(glen)] = la[0];
            glen += 1;
            consume(1);
        end
        gsym++;
        if (gsym >= 8) send_group();
    endfunction

    // works out the compressed bytes that one accepted raw byte releases
    function automatic void compress_byte(logic [7:0] b, logic last);
        coded_byte_t c;
        step_q.delete();
        if (la_n < LaDepth) begin
            la[5'(la_n)] = b;
            la_n++;
        end
        if (last) begin
            while (la_n > 0) code_symbol();
            send_group();
        end else if (la_n >= MaxMatch) begin
            code_symbol();
        end
        foreach (step_q[i]) begin
            c.data = step_q[i];
            c.last = last && (i == step_q.size() - 1);
            c.too_long = ovf;
            coded_q.push_back(c);
        end
        if (last) clear_stream();
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fails++;
    endtask

    // monitor: checks results, runs the model on accepted requests, watchdog
    always @(posedge aclk) begin
        coded_byte_t c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (coded_q.size() == 0) begin
                    report("unexpected byte", int'(m_tdata), 0);
                end else begin
                    c = coded_q.pop_front();
                    if (m_tdata !== c.data) report("out_byte", int'(m_tdata), int'(c.data));
                    if (m_tlast !== c.last) report("out_last", int'(m_tlast), int'(c.last));
                    if (m_tuser !== c.too_long)
                        report("too_long", int'(m_tuser), int'(c.too_long));
                end
            end
            if (s_tvalid && s_tready) compress_byte(s_tdata, s_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("timeout, no request moved for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
            s_took <= s_tvalid && s_tready;
        end
    end

    // request driver
    always @(negedge aclk) begin
        raw_byte_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (raw_q.size() > 0) begin
                it = raw_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tlast <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            snk_gap <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_byte(logic [7:0] b, logic last);
        raw_byte_t it;
        it.data = b;
        it.last = last;
        raw_q.push_back(it);
    endtask

    task automatic push_stream(logic [7:0] buffer[$]);
        foreach (buffer[i]) push_byte(buffer[i], i == buffer.size() - 1);
    endtask

    // mostly literal runs, back references and byte runs; noisy streams are pure random
    task automatic random_stream(int len, bit noisy);
        logic [7:0] buffer[$];
        int d;
        int n;
        logic [7:0] b;
        while (buffer.size() < len) begin
            case (noisy ? 0 : $urandom_range(0, 3))
                0: buffer.push_back(8'($urandom_range(0, 255)));
                1: begin
                    if (buffer.size() >= 2) begin
                        d = $urandom_range(2, buffer.size() < 60 ? buffer.size() : 60);
                        n = $urandom_range(2, 20);
                        for (int i = 0; i < n; i++)
                            buffer.push_back(buffer[buffer.size() - d]);
                    end
                end
                2: begin
                    b = 8'($urandom_range(0, 255));
                    n = $urandom_range(3, 25);
                    repeat (n) buffer.push_back(b);
                end
                default: buffer.push_back(8'($urandom_range(0, 3) ? 8'h41 + $urandom_range(0, 3)
                                                                  : $urandom_range(0, 255)));
            endcase
        end
        while (buffer.size() > len) void'(buffer.pop_back());
        push_stream(buffer);
    endtask

    task automatic wait_drained();
        while (raw_q.size() > 0 || s_tvalid || coded_q.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_key(int idx, logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_wr_data <= value;
        keys[3'(idx)] = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [7:0] buffer[$];
        foreach (keys[i]) keys[i] = KeyReset[i];
        foreach (hist[i]) hist[i] = '0;
        foreach (pos_tab[i]) pos_tab[i] = '0;
        clear_stream();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: tiny streams, extreme bytes, distance-two repeats, byte runs
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        buffer = {};
        repeat (20) begin
            buffer.push_back(8'h61);
            buffer.push_back(8'h62);
        end
        push_stream(buffer);
        buffer = {};
        repeat (30) buffer.push_back(8'hA5);
        push_stream(buffer);
        wait_drained();

        foreach (keys[i]) write_key(i, 16'h0000);
        random_stream(50, 1'b0);
        random_stream(20, 1'b1);
        wait_drained();

        foreach (keys[i]) write_key(i, 16'hFFFF);
        random_stream(60, 1'b0);
        wait_drained();

        foreach (keys[i]) write_key(i, 16'($urandom_range(0, 65535)));
        random_stream(70, 1'b0);
        random_stream(15, 1'b1);
        wait_drained();

        foreach (keys[i]) write_key(i, 16'($urandom_range(0, 65535)));
        calm = 1'b1;
        random_stream(90, 1'b0);
        wait_drained();

        repeat (200) @(posedge aclk);
        while (coded_q.size() > 0) begin
            report("missing byte", 0, int'(coded_q[0].data));
            void'(coded_q.pop_front());
        end
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
